/* hw/rtl/mscpu_pkg.sv */
// package: opcodes, step codes, action codes and result view type for the cpu core
package mscpu_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned AddrW = 4;
  localparam int unsigned StepW = 3;
  localparam int unsigned MemDepth = 1 << AddrW;

  typedef enum logic [3:0] {
    OP_NOP = 4'd0,
    OP_LDA = 4'd1,
    OP_ADD = 4'd2,
    OP_SUB = 4'd3,
    OP_STA = 4'd4,
    OP_LDI = 4'd5,
    OP_JMP = 4'd6,
    OP_JC  = 4'd7,
    OP_JZ  = 4'd8,
    OP_OUT = 4'd14,
    OP_HLT = 4'd15
  } op_e;

  localparam logic [StepW-1:0] StepFetchAddr  = 3'd0;
  localparam logic [StepW-1:0] StepFetchInstr = 3'd1;
  localparam logic [StepW-1:0] StepExec0      = 3'd2;
  localparam logic [StepW-1:0] StepExec1      = 3'd3;
  localparam logic [StepW-1:0] StepExec2      = 3'd4;

  localparam logic ActTick  = 1'b0;
  localparam logic ActWrite = 1'b1;

  typedef struct packed {
    logic             ticked;
    logic [DataW-1:0] out_value;
    logic [DataW-1:0] acc_value;
    logic [AddrW-1:0] prog_counter;
    logic [DataW-1:0] instr_value;
    logic [StepW-1:0] micro_step;
    logic             carry_flag;
    logic             zero_flag;
    logic             halted;
  } view_t;

endpackage

/* hw/rtl/mscpu_exec.sv */
// cpu state registers, program memory and the per-beat microstep logic
module mscpu_exec (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        action_i,
  input  logic [mscpu_pkg::AddrW-1:0] mem_addr_i,
  input  logic [mscpu_pkg::DataW-1:0] mem_data_i,
  output mscpu_pkg::view_t            view_o
);
  import mscpu_pkg::*;

  logic [DataW-1:0] mem_q [MemDepth];
  logic [AddrW-1:0] pc_q, pc_d, mar_q, mar_d;
  logic [DataW-1:0] ir_q, ir_d, a_q, a_d, b_q, b_d, sum_q, sum_d, out_q, out_d;
  logic             carry_q, carry_d, zero_q, zero_d, halt_q, halt_d;
  logic [StepW-1:0] step_q, step_d;
  logic             ticked;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [DataW-1:0] mem_rd;
  logic [DataW:0]   add_full;
  op_e              op;
  logic [AddrW-1:0] arg;

  assign mem_rd   = mem_q[mar_q];
  assign op       = op_e'(ir_q[DataW-1:AddrW]);
  assign arg      = ir_q[AddrW-1:0];
  assign add_full = {1'b0, a_q} + {1'b0, b_q};

  always_comb begin
    pc_d      = pc_q;
    mar_d     = mar_q;
    ir_d      = ir_q;
    a_d       = a_q;
    b_d       = b_q;
    sum_d     = sum_q;
    out_d     = out_q;
    carry_d   = carry_q;
    zero_d    = zero_q;
    halt_d    = halt_q;
    step_d    = step_q;
    ticked    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = mem_addr_i;
    mem_wdata = mem_data_i;
    if (fire_i) begin
      if (action_i == ActWrite) begin
        mem_we = 1'b1;
      end else if (!halt_q) begin
        ticked = 1'b1;
        step_d = (step_q == StepExec2) ? StepFetchAddr : step_q + 3'd1;
        if (step_q == StepFetchAddr) begin
          mar_d = pc_q;
        end else if (step_q == StepFetchInstr) begin
          ir_d = mem_rd;
          pc_d = pc_q + 4'd1;
        end else begin
          unique case (op)
            OP_LDA: begin
              if (step_q == StepExec0) mar_d = arg;
              else if (step_q == StepExec1) a_d = mem_rd;
            end
            OP_ADD, OP_SUB: begin
              if (step_q == StepExec0) begin
                mar_d = arg;
              end else if (step_q == StepExec1) begin
                b_d   = mem_rd;
                sum_d = (op == OP_ADD) ? a_q + mem_rd : a_q - mem_rd;
              end else if (step_q == StepExec2) begin
                carry_d = (op == OP_ADD) ? add_full[DataW] : (a_q >= b_q);
                zero_d  = (sum_q == '0);
                a_d     = sum_q;
              end
            end
            OP_STA: begin
              if (step_q == StepExec0) begin
                mar_d = arg;
              end else if (step_q == StepExec1) begin
                mem_we    = 1'b1;
                mem_waddr = mar_q;
                mem_wdata = a_q;
              end
            end
            OP_LDI: if (step_q == StepExec0) a_d = {{(DataW-AddrW){1'b0}}, arg};
            OP_JMP: if (step_q == StepExec0) pc_d = arg;
            OP_JC:  if (step_q == StepExec0 && carry_q) pc_d = arg;
            OP_JZ:  if (step_q == StepExec0 && zero_q) pc_d = arg;
            OP_OUT: if (step_q == StepExec0) out_d = a_q;
            OP_HLT: if (step_q == StepExec0) halt_d = 1'b1;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MemDepth; i++) mem_q[i] <= '0;
    end else if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      mar_q   <= '0;
      ir_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      sum_q   <= '0;
      out_q   <= '0;
      carry_q <= 1'b0;
      zero_q  <= 1'b0;
      halt_q  <= 1'b0;
      step_q  <= StepFetchAddr;
    end else begin
      pc_q    <= pc_d;
      mar_q   <= mar_d;
      ir_q    <= ir_d;
      a_q     <= a_d;
      b_q     <= b_d;
      sum_q   <= sum_d;
      out_q   <= out_d;
      carry_q <= carry_d;
      zero_q  <= zero_d;
      halt_q  <= halt_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    view_o.ticked       = ticked;
    view_o.out_value    = out_d;
    view_o.acc_value    = a_d;
    view_o.prog_counter = pc_d;
    view_o.instr_value  = ir_d;
    view_o.micro_step   = step_d;
    view_o.carry_flag   = carry_d;
    view_o.zero_flag    = zero_d;
    view_o.halted       = halt_d;
  end

endmodule

/* hw/rtl/microstepped_8bit_cpu_core.sv */
// top level: input register, microstep logic and result register of the cpu core
//
//  channel | direction | beat contents
//  in      | in        | action_i, mem_addr_i, mem_data_i
//  out     | out       | ticked_o, out/acc/pc/ir/step, flags, halted_o
//
// one beat per cycle sustained while out_ready_i is high; each beat passes the input and result registers
// the input register feeds the microstep logic, which updates the cpu state and
// loads the result register in the same edge
// reset clears the cpu state and all 16 memory bytes at once
// a stalled result holds the input register, so in_ready_o drops only under
// backpressure on the output
module microstepped_8bit_cpu_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [mscpu_pkg::AddrW-1:0] mem_addr_i,
  input  logic [mscpu_pkg::DataW-1:0] mem_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ticked_o,
  output logic [mscpu_pkg::DataW-1:0] out_value_o,
  output logic [mscpu_pkg::DataW-1:0] acc_value_o,
  output logic [mscpu_pkg::AddrW-1:0] prog_counter_o,
  output logic [mscpu_pkg::DataW-1:0] instr_value_o,
  output logic [mscpu_pkg::StepW-1:0] micro_step_o,
  output logic                        carry_flag_o,
  output logic                        zero_flag_o,
  output logic                        halted_o
);
  import mscpu_pkg::*;

  logic             in_vld_q;
  logic             action_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] data_q;
  logic             out_vld_q;
  view_t            res_q;
  view_t            view;
  logic             advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  mscpu_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .action_i   (action_q),
    .mem_addr_i (addr_q),
    .mem_data_i (data_q),
    .view_o     (view)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q <= action_i;
      addr_q   <= mem_addr_i;
      data_q   <= mem_data_i;
    end
    if (advance) res_q <= view;
  end

  assign out_valid_o    = out_vld_q;
  assign ticked_o       = res_q.ticked;
  assign out_value_o    = res_q.out_value;
  assign acc_value_o    = res_q.acc_value;
  assign prog_counter_o = res_q.prog_counter;
  assign instr_value_o  = res_q.instr_value;
  assign micro_step_o   = res_q.micro_step;
  assign carry_flag_o   = res_q.carry_flag;
  assign zero_flag_o    = res_q.zero_flag;
  assign halted_o       = res_q.halted;

endmodule

/* hw/rtl/mscpu_checker.sv */
// port-level checker for the cpu core, bound to the top level
module mscpu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        ticked_o,
  input logic [mscpu_pkg::StepW-1:0] micro_step_o,
  input logic                        halted_o
);
  import mscpu_pkg::*;

  // input side only stalls behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // halt is taken in the first execute step, so the step counter parks one past it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> micro_step_o == StepExec1)
    else $error("halted with wrong micro step");

  // step counter never leaves its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> micro_step_o <= StepExec2)
    else $error("micro step out of range");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ticked_o)
      && $stable(micro_step_o) && $stable(halted_o))
    else $error("result changed while stalled");

endmodule

bind microstepped_8bit_cpu_core mscpu_checker u_mscpu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .ticked_o     (ticked_o),
  .micro_step_o (micro_step_o),
  .halted_o     (halted_o)
);
